@@ hdl/emr_pkg.sv @@
// ---------------------------------------------------------------------------
// emr_pkg - shared definitions of the midpoint ellipse rasterizer
// Default coordinate width, command codes and the result control group
// passed from the sequencer to the output stage.
// ---------------------------------------------------------------------------
package emr_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // control group of one result offered by the sequencer
  typedef struct packed {
    logic valid;
    logic last;
    logic fin;
  } emr_emit_t;

endpackage

@@ hdl/midpoint_ellipse_rasterizer_unit.sv @@
// ---------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_unit - integer midpoint ellipse rasterizer
// A start command sets up an ellipse and yields its first four pixels; each
// step command runs one midpoint iteration and yields four pixels, or one
// finished marker once the ellipse is done.
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                      tuser     tlast
// s_axis   in   center_x, center_y, radius_x, radius_y  command   -
// m_axis   out  pixel_x, pixel_y                        finished  last_of_group
//
// s_axis_tready_o is high only while the sequencer is idle; one item at a time.
// start: setup on the shared multiplier and adder, then 4 transfers.
// step: work on the shared adder, with the shared multiplier too on region
// two entry, then 4 transfers; a step with nothing left gives one transfer.
// one result is emitted per cycle into the output register; stalls on m_axis
// hold the sequencer. reset returns to idle with no ellipse active.
// ---------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_unit #(
  parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF,
  parameter int IN_W  = ((4 * COORD_BITS - 2 + 7) / 8) * 8,
  parameter int OUT_W = ((2 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // center_x, center_y, radius_x, radius_y
  input  logic             s_axis_tuser_i,   // command
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // pixel_x, pixel_y
  output logic             m_axis_tuser_o,   // finished
  output logic             m_axis_tlast_o    // last_of_group
);

  localparam int C   = COORD_BITS;
  localparam int PIX = COORD_BITS + 2;

  emr_pkg::emr_emit_t emit;
  logic [PIX-1:0]     pix_x, pix_y;
  logic               emit_ack;

  logic           out_vld_q;
  logic [PIX-1:0] out_x_q, out_y_q;
  logic           out_last_q, out_fin_q;

  emr_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .center_x_i (s_axis_tdata_i[C-1:0]),
    .center_y_i (s_axis_tdata_i[2*C-1:C]),
    .radius_x_i (s_axis_tdata_i[3*C-2:2*C]),
    .radius_y_i (s_axis_tdata_i[4*C-3:3*C-1]),
    .emit_o     (emit),
    .pix_x_o    (pix_x),
    .pix_y_o    (pix_y),
    .emit_ack_i (emit_ack)
  );

  // output register takes a result when empty or draining this cycle
  assign emit_ack = emit.valid && (!out_vld_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_ack) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ack) begin
      out_x_q    <= pix_x;
      out_y_q    <= pix_y;
      out_last_q <= emit.last;
      out_fin_q  <= emit.fin;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_W'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_fin_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ hdl/emr_mult.sv @@
// ---------------------------------------------------------------------------
// emr_mult - shared signed multiplier
// One registered signed product per cycle; the sequencer picks the operands
// and reads the product in the next cycle.
// ---------------------------------------------------------------------------
module emr_mult #(
  parameter int OP_W = 24
) (
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   op_a_i,
  input  logic signed [OP_W-1:0]   op_b_i,
  output logic signed [2*OP_W-1:0] prod_o
);

  logic signed [2*OP_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/emr_core.sv @@
// ---------------------------------------------------------------------------
// emr_core - sequencer and datapath of the midpoint ellipse rasterizer
// Holds the ellipse state, runs setup, region one, region two entry and
// region two steps over a shared multiplier and a shared adder, and offers
// the four symmetric pixels or a finished marker one at a time.
// ---------------------------------------------------------------------------
module emr_core #(
  parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  input  logic [COORD_BITS-2:0]   radius_x_i,
  input  logic [COORD_BITS-2:0]   radius_y_i,
  output emr_pkg::emr_emit_t      emit_o,
  output logic [COORD_BITS+1:0]   pix_x_o,
  output logic [COORD_BITS+1:0]   pix_y_o,
  input  logic                    emit_ack_i
);

  localparam int R      = COORD_BITS - 1;
  localparam int PIX    = COORD_BITS + 2;
  localparam int SQ_W   = 2 * R;
  localparam int OP_W   = 2 * R + 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int STEP_W = 3 * R + 2;
  localparam int W      = 4 * R + 6;

  typedef enum logic [22:0] {
    S_IDLE   = 23'b1 << 0,
    S_SQY    = 23'b1 << 1,
    S_RXRY   = 23'b1 << 2,
    S_INIT_A = 23'b1 << 3,
    S_INIT_B = 23'b1 << 4,
    S_EMIT   = 23'b1 << 5,
    S_FIN    = 23'b1 << 6,
    S_R1_CMP = 23'b1 << 7,
    S_R1_X   = 23'b1 << 8,
    S_R1_Y   = 23'b1 << 9,
    S_DX     = 23'b1 << 10,
    S_DY     = 23'b1 << 11,
    S_DQ     = 23'b1 << 12,
    S_R2_CHK = 23'b1 << 13,
    S_R2_X   = 23'b1 << 14,
    S_E_XX   = 23'b1 << 15,
    S_E_XS   = 23'b1 << 16,
    S_E_YS   = 23'b1 << 17,
    S_E_P1   = 23'b1 << 18,
    S_E_P2   = 23'b1 << 19,
    S_E_P3   = 23'b1 << 20,
    S_E_Q    = 23'b1 << 21,
    S_E_T    = 23'b1 << 22
  } emr_state_e;

  emr_state_e state_q, state_d;
  logic       active_q, active_d;
  logic       r2_q, r2_d;
  logic       br_q, br_d;
  logic [1:0] cnt_q, cnt_d;

  logic [COORD_BITS-1:0]   orig_x_q, orig_x_d;
  logic [COORD_BITS-1:0]   orig_y_q, orig_y_d;
  logic [R-1:0]            off_x_q, off_x_d;
  logic [R-1:0]            off_y_q, off_y_d;
  logic [SQ_W-1:0]         rx2_q, rx2_d;
  logic [SQ_W-1:0]         ry2_q, ry2_d;
  logic signed [STEP_W-1:0] stepx_q, stepx_d;
  logic signed [STEP_W-1:0] stepy_q, stepy_d;
  logic signed [W-1:0]     dec_q, dec_d;
  logic signed [R:0]       ym1_q, ym1_d;
  logic [OP_W-1:0]         tmp_q, tmp_d;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [W-1:0]      prod_w;
  logic signed [W-1:0]      alu_a, alu_b, alu_r;
  logic                     alu_sub;

  emr_mult #(.OP_W(OP_W)) u_mult (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  assign prod_w = W'(prod);

  // shared adder operand selection
  always_comb begin
    alu_a   = dec_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_INIT_A: begin
        alu_a   = $signed(W'(ry2_q));
        alu_b   = prod_w;
        alu_sub = 1'b1;
      end
      S_INIT_B: alu_b = $signed(W'(rx2_q >> 2));
      S_R1_X, S_R2_X: begin
        alu_a = W'(stepx_q);
        alu_b = $signed(W'({ry2_q, 1'b0}));
      end
      S_R1_Y, S_R2_CHK: begin
        alu_a   = W'(stepy_q);
        alu_b   = $signed(W'({rx2_q, 1'b0}));
        alu_sub = 1'b1;
      end
      S_DX: alu_b = W'(stepx_q);
      S_DY: begin
        alu_b   = W'(stepy_q);
        alu_sub = 1'b1;
      end
      S_DQ: alu_b = r2_q ? $signed(W'(rx2_q)) : $signed(W'(ry2_q));
      S_E_XS: begin
        alu_a = prod_w;
        alu_b = $signed(W'(off_x_q));
      end
      S_E_P2: alu_b = prod_w;
      S_E_P3: begin
        alu_b   = prod_w;
        alu_sub = 1'b1;
      end
      S_E_Q: begin
        alu_a = dec_q <<< 2;
        alu_b = $signed(W'(ry2_q));
      end
      // bias a negative value so the shift truncates toward zero
      S_E_T: alu_b = dec_q[W-1] ? W'(3) : '0;
      default: ;
    endcase
    alu_r = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // multiplier operand selection, product used in the following state
  always_comb begin
    mul_a = $signed(OP_W'(rx2_q));
    mul_b = $signed(OP_W'(ry2_q));
    case (state_q)
      S_IDLE: begin
        mul_a = $signed(OP_W'(radius_x_i));
        mul_b = $signed(OP_W'(radius_x_i));
      end
      S_SQY: begin
        mul_a = $signed(OP_W'(off_y_q));
        mul_b = $signed(OP_W'(off_y_q));
      end
      S_RXRY: mul_b = $signed(OP_W'(off_y_q));
      S_E_XX: begin
        mul_a = $signed(OP_W'(off_x_q));
        mul_b = $signed(OP_W'(off_x_q));
      end
      S_E_XS: begin
        mul_a = OP_W'(ym1_q);
        mul_b = OP_W'(ym1_q);
      end
      S_E_YS: begin
        mul_a = $signed(OP_W'(ry2_q));
        mul_b = $signed(tmp_q);
      end
      S_E_P1: mul_b = $signed(tmp_q);
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    r2_d     = r2_q;
    br_d     = br_q;
    cnt_d    = cnt_q;
    orig_x_d = orig_x_q;
    orig_y_d = orig_y_q;
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    rx2_d    = rx2_q;
    ry2_d    = ry2_q;
    stepx_d  = stepx_q;
    stepy_d  = stepy_q;
    dec_d    = dec_q;
    ym1_d    = ym1_q;
    tmp_d    = tmp_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == emr_pkg::CMD_START) begin
            orig_x_d = center_x_i;
            orig_y_d = center_y_i;
            off_x_d  = '0;
            off_y_d  = radius_y_i;
            stepx_d  = '0;
            active_d = 1'b1;
            r2_d     = 1'b0;
            state_d  = S_SQY;
          end else if (!active_q) begin
            state_d = S_FIN;
          end else if (r2_q) begin
            state_d = S_R2_CHK;
          end else begin
            state_d = S_R1_CMP;
          end
        end
      end
      S_SQY: begin
        rx2_d   = prod[SQ_W-1:0];
        state_d = S_RXRY;
      end
      S_RXRY: begin
        ry2_d   = prod[SQ_W-1:0];
        state_d = S_INIT_A;
      end
      S_INIT_A: begin
        stepy_d = $signed(STEP_W'({prod, 1'b0}));
        dec_d   = alu_r;
        state_d = S_INIT_B;
      end
      S_INIT_B: begin
        dec_d   = alu_r;
        cnt_d   = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ack_i) begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (emit_ack_i) begin
          state_d = S_IDLE;
        end
      end
      S_R1_CMP: begin
        state_d = (stepx_q < stepy_q) ? S_R1_X : S_E_XX;
      end
      S_R1_X: begin
        off_x_d = off_x_q + R'(1);
        stepx_d = STEP_W'(alu_r);
        br_d    = dec_q[W-1];
        state_d = S_DX;
      end
      S_R1_Y: begin
        off_y_d = off_y_q - R'(1);
        stepy_d = STEP_W'(alu_r);
        state_d = S_DY;
      end
      S_DX: begin
        dec_d = alu_r;
        if (r2_q) begin
          state_d = S_DY;
        end else begin
          state_d = br_q ? S_DQ : S_R1_Y;
        end
      end
      S_DY: begin
        dec_d   = alu_r;
        state_d = S_DQ;
      end
      S_DQ: begin
        dec_d   = alu_r;
        cnt_d   = '0;
        state_d = S_EMIT;
      end
      S_R2_CHK: begin
        if (off_y_q == '0) begin
          active_d = 1'b0;
          r2_d     = 1'b0;
          state_d  = S_FIN;
        end else begin
          off_y_d = off_y_q - R'(1);
          stepy_d = STEP_W'(alu_r);
          br_d    = dec_q > 0;
          state_d = (dec_q > 0) ? S_DY : S_R2_X;
        end
      end
      S_R2_X: begin
        off_x_d = off_x_q + R'(1);
        stepx_d = STEP_W'(alu_r);
        state_d = S_DX;
      end
      S_E_XX: begin
        ym1_d   = $signed({1'b0, off_y_q}) - (R+1)'(1);
        state_d = S_E_XS;
      end
      S_E_XS: begin
        tmp_d   = OP_W'(alu_r);
        state_d = S_E_YS;
      end
      S_E_YS: begin
        // the multiplier reads x*x + x now, the register takes (y-1)^2
        tmp_d   = OP_W'(prod);
        state_d = S_E_P1;
      end
      S_E_P1: begin
        dec_d   = prod_w;
        state_d = S_E_P2;
      end
      S_E_P2: begin
        dec_d   = alu_r;
        state_d = S_E_P3;
      end
      S_E_P3: begin
        dec_d   = alu_r;
        state_d = S_E_Q;
      end
      S_E_Q: begin
        dec_d   = alu_r;
        state_d = S_E_T;
      end
      S_E_T: begin
        dec_d   = alu_r >>> 2;
        r2_d    = 1'b1;
        state_d = S_R2_CHK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      active_q <= 1'b0;
      r2_q     <= 1'b0;
      br_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      r2_q     <= r2_d;
      br_q     <= br_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    orig_x_q <= orig_x_d;
    orig_y_q <= orig_y_d;
    off_x_q  <= off_x_d;
    off_y_q  <= off_y_d;
    rx2_q    <= rx2_d;
    ry2_q    <= ry2_d;
    stepx_q  <= stepx_d;
    stepy_q  <= stepy_d;
    dec_q    <= dec_d;
    ym1_q    <= ym1_d;
    tmp_q    <= tmp_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // pixel order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  always_comb begin
    emit_o.valid = (state_q == S_EMIT) || (state_q == S_FIN);
    emit_o.last  = (state_q == S_FIN) || (cnt_q == 2'd3);
    emit_o.fin   = (state_q == S_FIN);
    if (state_q == S_FIN) begin
      pix_x_o = '0;
      pix_y_o = '0;
    end else begin
      pix_x_o = cnt_q[0] ? (PIX'(orig_x_q) - PIX'(off_x_q)) : (PIX'(orig_x_q) + PIX'(off_x_q));
      pix_y_o = cnt_q[1] ? (PIX'(orig_y_q) - PIX'(off_y_q)) : (PIX'(orig_y_q) + PIX'(off_y_q));
    end
  end

endmodule

@@ hdl/emr_checker.sv @@
// ---------------------------------------------------------------------------
// emr_checker - port level checks of the ellipse rasterizer
// Watches the stream ports of the top level; attached by bind below.
// ---------------------------------------------------------------------------
module emr_checker #(
  parameter int COORD_BITS = emr_pkg::COORD_BITS_DEF,
  parameter int IN_W  = ((4 * COORD_BITS - 2 + 7) / 8) * 8,
  parameter int OUT_W = ((2 * (COORD_BITS + 2) + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_tvalid_i,
  input logic             s_tready_i,
  input logic [IN_W-1:0]  s_tdata_i,
  input logic             m_tvalid_i,
  input logic             m_tready_i,
  input logic [OUT_W-1:0] m_tdata_i,
  input logic             m_tuser_i,
  input logic             m_tlast_i
);

  // finished marker always closes its group
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tlast_i)
    else $error("finished result without tlast");

  // finished marker carries no pixel
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i |-> m_tdata_i == '0)
    else $error("finished result with nonzero pixel");

  // one item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && !$isunknown(s_tdata_i) |=> !s_tready_i)
    else $error("input ready right after a transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("stalled output changed");

endmodule

bind midpoint_ellipse_rasterizer_unit emr_checker #(
  .COORD_BITS (COORD_BITS),
  .IN_W       (IN_W),
  .OUT_W      (OUT_W)
) u_emr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tdata_i  (s_axis_tdata_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);
